@@ hdl/multichannel_pcm_mixer_unit_defines.svh @@
// Assertion macros shared by the mixer RTL.
// Every check is sampled on the rising edge of clk and is disabled while rst_n is low.
`ifndef MULTICHANNEL_PCM_MIXER_UNIT_DEFINES_SVH
`define MULTICHANNEL_PCM_MIXER_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MPM_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MPM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/mpm_pkg.sv @@
package mpm_pkg;

    // Widths of the payload fields.
    localparam int ACTION_W  = 3;
    localparam int ADDRESS_W = 16;
    localparam int BYTE_W    = 8;
    localparam int LENGTH_W  = 17;
    localparam int VOLUME_W  = 7;
    localparam int HANDLE_W  = 4;
    localparam int MIX_W     = 16;

    // Bias of unsigned PCM, shift of the volume scale and limits of the output.
    localparam int SAMPLE_BIAS = 128;
    localparam int VOL_SHIFT   = 7;
    localparam int MIX_MAX     = 32767;
    localparam int MIX_MIN     = -32768;

    typedef enum logic [ACTION_W-1:0] {
        ACT_WRITE  = 3'd0,
        ACT_START  = 3'd1,
        ACT_STOP   = 3'd2,
        ACT_VOLUME = 3'd3,
        ACT_QUERY  = 3'd4,
        ACT_MIX    = 3'd5
    } action_t;

endpackage

@@ hdl/multichannel_pcm_mixer_unit.sv @@
// Multichannel PCM mixer: plays up to CHANNELS sounds of 8-bit unsigned PCM out of an
// internal sample memory and mixes them into one clipped signed 16-bit sample.
// Input channel: in_valid / in_stall carries action, address, sample_byte, sound_length,
// channel_volume and handle_in. Every input transfer gives exactly one result transfer on
// out_valid / out_stall with mixed_sample, handle_out and playing.
// Configuration: cfg_valid / cfg_ready writes master_volume from cfg_data. The port is
// always ready; write it only while the block is idle.
// Latency: write, start, stop, set volume and query give their result in the cycle after
// the input transfer. A mix frame walks the channels through one shared multiplier:
// each playing channel passes through S_FETCH, S_MUL and S_ACC and each idle channel
// through S_FETCH alone, then S_MASTER applies the master volume and S_OUT clips the sum.
// One item is in work at a time; in_stall stays high until its result sits in the output
// register. The output register holds its result while out_stall is high, and a new item
// is taken only once the output register is free or is being drained in the same cycle.
// Reset makes every channel idle and sets master_volume to 127. The sample memory is not
// cleared; SAMPLE_MEM_DEPTH must be a power of two and addresses wrap modulo its depth.
module multichannel_pcm_mixer_unit #(
    parameter int CHANNELS         = 8,
    parameter int SAMPLE_MEM_DEPTH = 65536
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic [mpm_pkg::ACTION_W-1:0]           action,
    input  logic [mpm_pkg::ADDRESS_W-1:0]          address,
    input  logic [mpm_pkg::BYTE_W-1:0]             sample_byte,
    input  logic [mpm_pkg::LENGTH_W-1:0]           sound_length,
    input  logic [mpm_pkg::VOLUME_W-1:0]           channel_volume,
    input  logic [mpm_pkg::HANDLE_W-1:0]           handle_in,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic signed [mpm_pkg::MIX_W-1:0]       mixed_sample,
    output logic [mpm_pkg::HANDLE_W-1:0]           handle_out,
    output logic                                   playing,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [mpm_pkg::VOLUME_W-1:0]           cfg_data
);
    import mpm_pkg::*;

    `include "multichannel_pcm_mixer_unit_defines.svh"

    localparam int CW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int AW    = $clog2(SAMPLE_MEM_DEPTH);
    localparam int SUMW  = (AW > LENGTH_W + 1) ? AW : LENGTH_W + 1;
    localparam int ACCW  = 2 * BYTE_W + $clog2(CHANNELS);
    localparam int PW    = ACCW + BYTE_W;
    localparam int SCW   = PW - VOL_SHIFT;
    localparam int HSUMW = 6;

    localparam logic signed [SCW-1:0] CLIP_HI = SCW'(MIX_MAX);
    localparam logic signed [SCW-1:0] CLIP_LO = SCW'(MIX_MIN);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_FETCH  = 6'b000010,
        S_MUL    = 6'b000100,
        S_ACC    = 6'b001000,
        S_MASTER = 6'b010000,
        S_OUT    = 6'b100000
    } state_t;

    state_t                     state_reg, state_next;
    logic [CW-1:0]              chan_idx_reg, chan_idx_next;
    logic [CHANNELS-1:0]        active_reg, active_next;
    logic [ADDRESS_W-1:0]       base_reg   [CHANNELS];
    logic [LENGTH_W-1:0]        length_reg [CHANNELS];
    logic [LENGTH_W-1:0]        pos_reg    [CHANNELS];
    logic [VOLUME_W-1:0]        gain_reg   [CHANNELS];
    logic [VOLUME_W-1:0]        master_reg;
    logic signed [ACCW-1:0]     acc_reg;
    logic signed [PW-1:0]       prod_reg;

    logic [BYTE_W-1:0]          sample_mem [SAMPLE_MEM_DEPTH];
    logic [BYTE_W-1:0]          mem_rdata_reg;

    logic                       out_valid_reg;
    logic signed [MIX_W-1:0]    mixed_reg;
    logic [HANDLE_W-1:0]        handle_reg;
    logic                       playing_reg;

    logic                       in_accept;
    logic                       out_free;
    action_t                    act;
    logic [CW-1:0]              free_idx;
    logic [HSUMW-1:0]           start_handle;
    logic [HSUMW-1:0]           handle_m1;
    logic [CW-1:0]              handle_idx;
    logic                       handle_ok;
    logic                       last_chan;
    logic                       chan_live;
    logic [SUMW-1:0]            rd_sum;
    logic [SUMW-1:0]            wr_sum;
    logic signed [BYTE_W:0]     sample_sgn;
    logic signed [ACCW-1:0]     mul_a;
    logic signed [BYTE_W-1:0]   mul_b;
    logic signed [PW-1:0]       mul_p;
    logic signed [SCW-1:0]      scaled;
    logic signed [MIX_W-1:0]    clipped;

    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != S_IDLE) || !out_free;
    assign in_accept = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign act       = action_t'(action);

    assign out_valid    = out_valid_reg;
    assign mixed_sample = mixed_reg;
    assign handle_out   = handle_reg;
    assign playing      = playing_reg;

    // The first idle channel takes a new sound; channel 0 is stolen when none is idle.
    always_comb
    begin
        free_idx = '0;
        for (int c = CHANNELS - 1; c >= 0; c--)
        begin
            if (!active_reg[c])
            begin
                free_idx = CW'(c);
            end
        end
    end

    assign start_handle = HSUMW'(free_idx) + HSUMW'(1);
    assign handle_m1    = HSUMW'(handle_in) - HSUMW'(1);
    assign handle_idx   = handle_m1[CW-1:0];
    assign handle_ok    = (handle_in != '0) && (HSUMW'(handle_in) <= HSUMW'(CHANNELS));

    assign last_chan = (chan_idx_reg == CW'(CHANNELS - 1));
    assign chan_live = active_reg[chan_idx_reg] &&
                       (pos_reg[chan_idx_reg] < length_reg[chan_idx_reg]);

    assign rd_sum = SUMW'(base_reg[chan_idx_reg]) + SUMW'(pos_reg[chan_idx_reg]);
    assign wr_sum = SUMW'(address);

    // One multiplier serves every channel term and then the master volume.
    assign sample_sgn = $signed({1'b0, mem_rdata_reg}) - $signed((BYTE_W + 1)'(SAMPLE_BIAS));
    assign mul_a = (state_reg == S_MASTER) ? acc_reg : ACCW'(sample_sgn);
    assign mul_b = (state_reg == S_MASTER) ? $signed({1'b0, master_reg})
                                           : $signed({1'b0, gain_reg[chan_idx_reg]});
    assign mul_p = PW'(mul_a) * PW'(mul_b);

    // Shifting right arithmetically gives the floor of the division by 128.
    assign scaled = SCW'(prod_reg >>> VOL_SHIFT);

    always_comb
    begin
        priority if (scaled > CLIP_HI)
        begin
            clipped = MIX_W'(MIX_MAX);
        end
        else if (scaled < CLIP_LO)
        begin
            clipped = MIX_W'(MIX_MIN);
        end
        else
        begin
            clipped = scaled[MIX_W-1:0];
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        chan_idx_next = chan_idx_reg;
        active_next   = active_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    unique case (act)
                        ACT_START:
                        begin
                            if (sound_length != '0)
                            begin
                                active_next[free_idx] = 1'b1;
                            end
                        end
                        ACT_STOP:
                        begin
                            if (handle_ok)
                            begin
                                active_next[handle_idx] = 1'b0;
                            end
                        end
                        ACT_MIX:
                        begin
                            state_next    = S_FETCH;
                            chan_idx_next = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_FETCH:
            begin
                if (chan_live)
                begin
                    state_next = S_MUL;
                end
                else
                begin
                    // A channel that has played its last sample goes idle here.
                    active_next[chan_idx_reg] = 1'b0;
                    if (last_chan)
                    begin
                        state_next = S_MASTER;
                    end
                    else
                    begin
                        chan_idx_next = chan_idx_reg + CW'(1);
                    end
                end
            end
            S_MUL:
            begin
                state_next = S_ACC;
            end
            S_ACC:
            begin
                if (last_chan)
                begin
                    state_next = S_MASTER;
                end
                else
                begin
                    state_next    = S_FETCH;
                    chan_idx_next = chan_idx_reg + CW'(1);
                end
            end
            S_MASTER:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            chan_idx_reg <= '0;
            active_reg   <= '0;
            master_reg   <= VOLUME_W'(127);
        end
        else
        begin
            state_reg    <= state_next;
            chan_idx_reg <= chan_idx_next;
            active_reg   <= active_next;
            if (cfg_valid && cfg_ready)
            begin
                master_reg <= cfg_data;
            end
        end
    end

    // Channel fields, the accumulator and the product register need no reset.
    always_ff @(posedge clk)
    begin
        if (in_accept && (act == ACT_START) && (sound_length != '0))
        begin
            base_reg[free_idx]   <= address;
            length_reg[free_idx] <= sound_length;
            pos_reg[free_idx]    <= '0;
            gain_reg[free_idx]   <= channel_volume;
        end
        if (in_accept && (act == ACT_VOLUME) && handle_ok)
        begin
            gain_reg[handle_idx] <= channel_volume;
        end
        if (in_accept && (act == ACT_MIX))
        begin
            acc_reg <= '0;
        end
        if ((state_reg == S_MUL) || (state_reg == S_MASTER))
        begin
            prod_reg <= mul_p;
        end
        if (state_reg == S_ACC)
        begin
            acc_reg                <= acc_reg + $signed(prod_reg[ACCW-1:0]);
            pos_reg[chan_idx_reg] <= pos_reg[chan_idx_reg] + LENGTH_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept && (act == ACT_WRITE))
        begin
            sample_mem[wr_sum[AW-1:0]] <= sample_byte;
        end
        mem_rdata_reg <= sample_mem[rd_sum[AW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if ((in_accept && (act != ACT_MIX)) || ((state_reg == S_OUT) && out_free))
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept && (act != ACT_MIX))
        begin
            mixed_reg   <= '0;
            handle_reg  <= '0;
            playing_reg <= 1'b0;
            if ((act == ACT_START) && (sound_length != '0))
            begin
                handle_reg <= start_handle[HANDLE_W-1:0];
            end
            if ((act == ACT_QUERY) && handle_ok)
            begin
                playing_reg <= active_reg[handle_idx];
            end
        end
        else if ((state_reg == S_OUT) && out_free)
        begin
            mixed_reg   <= clipped;
            handle_reg  <= '0;
            playing_reg <= 1'b0;
        end
    end

    `MPM_ASSERT_NEXT(a_quick_result, in_accept && (action != ACT_MIX), out_valid,
                     "a single-cycle action gave no result")
    `MPM_ASSERT_NEXT(a_mix_starts, in_accept && (action == ACT_MIX),
                     (state_reg == S_FETCH) && (chan_idx_reg == '0),
                     "a mix frame did not start at the first channel")
    `MPM_ASSERT_NEXT(a_mix_done, (state_reg == S_OUT) && out_free,
                     (state_reg == S_IDLE) && out_valid,
                     "a finished mix frame was not delivered")
    `MPM_ASSERT_NEXT(a_start_active,
                     in_accept && (action == ACT_START) && (sound_length != '0),
                     $countones(active_reg) >= 1, "a started sound left every channel idle")
    `MPM_ASSERT_SAME(a_busy_stalls, (state_reg != S_IDLE) && (state_reg != S_OUT),
                     !out_valid || ($past(state_reg) != S_OUT),
                     "a mix result appeared before the frame was done")

endmodule

@@ bench/pcm_mixer_checker.sv @@
`timescale 1ns / 100ps

module pcm_mixer_checker
    import mpm_pkg::*;
#(
    parameter int CHANNELS = 8
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic                        in_stall,
    input  logic [ACTION_W-1:0]         action,
    input  logic [ADDRESS_W-1:0]        address,
    input  logic [BYTE_W-1:0]           sample_byte,
    input  logic [LENGTH_W-1:0]         sound_length,
    input  logic [VOLUME_W-1:0]         channel_volume,
    input  logic [HANDLE_W-1:0]         handle_in,
    input  logic                        out_valid,
    input  logic                        out_stall,
    input  logic signed [MIX_W-1:0]     mixed_sample,
    input  logic [HANDLE_W-1:0]         handle_out,
    input  logic                        playing,
    input  logic                        cfg_valid,
    input  logic                        cfg_ready,
    input  logic [VOLUME_W-1:0]         cfg_data,
    output int                          mismatch_total,
    output int                          items_taken,
    output int                          results_taken,
    output int                          backlog,
    output int                          clipped_frames
);

    localparam logic [VOLUME_W-1:0] MASTER_AT_RESET = 7'd127;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [MIX_W-1:0]    mix;
        logic [HANDLE_W-1:0] handle;
        logic                play;
    } mixer_reply_t;

    logic [BYTE_W-1:0]    sample_copy [0:(1 << ADDRESS_W)-1];
    logic [ADDRESS_W-1:0] snd_base   [CHANNELS];
    logic [LENGTH_W-1:0]  snd_length [CHANNELS];
    logic [LENGTH_W-1:0]  snd_pos    [CHANNELS];
    logic [VOLUME_W-1:0]  snd_gain   [CHANNELS];
    bit                   snd_active [CHANNELS];
    logic [VOLUME_W-1:0]  master;

    mixer_reply_t awaited_replies [$];
    int n_items;
    int n_results;
    int n_bad;
    int n_clipped;

    // Applies one item to the local copy of the mixer and returns the reply it must give.
    function automatic mixer_reply_t mixer_reply_for(action_t act, logic [ADDRESS_W-1:0] addr,
                                                     logic [BYTE_W-1:0] pcm,
                                                     logic [LENGTH_W-1:0] len,
                                                     logic [VOLUME_W-1:0] vol,
                                                     logic [HANDLE_W-1:0] hdl);
        mixer_reply_t reply;
        int ch;
        int slot;
        bit found;
        int s;
        int acc;
        logic [ADDRESS_W-1:0] rd;
        reply = '0;
        ch = (hdl >= 1 && hdl <= CHANNELS) ? int'(hdl) - 1 : -1;
        case (act)
            ACT_WRITE: sample_copy[addr] = pcm;
            ACT_START:
            begin
                if (len != 0)
                begin
                    // With every channel busy the sound takes over channel 0.
                    slot = 0;
                    found = 1'b0;
                    for (int c = 0; c < CHANNELS; c++)
                    begin
                        if (!found && !snd_active[c])
                        begin
                            slot = c;
                            found = 1'b1;
                        end
                    end
                    snd_base[slot] = addr;
                    snd_length[slot] = len;
                    snd_pos[slot] = '0;
                    snd_gain[slot] = vol;
                    snd_active[slot] = 1'b1;
                    reply.handle = HANDLE_W'(slot + 1);
                end
            end
            ACT_STOP:
            begin
                if (ch >= 0)
                    snd_active[ch] = 1'b0;
            end
            ACT_VOLUME:
            begin
                if (ch >= 0)
                    snd_gain[ch] = vol;
            end
            ACT_QUERY:
            begin
                if (ch >= 0 && snd_active[ch])
                    reply.play = 1'b1;
            end
            ACT_MIX:
            begin
                acc = 0;
                for (int c = 0; c < CHANNELS; c++)
                begin
                    if (snd_active[c])
                    begin
                        if (snd_pos[c] >= snd_length[c])
                            snd_active[c] = 1'b0;
                        else
                        begin
                            rd = snd_base[c] + snd_pos[c][ADDRESS_W-1:0];
                            s = (int'(sample_copy[rd]) - SAMPLE_BIAS) * (1 << VOL_SHIFT);
                            acc += (s * int'(snd_gain[c])) >>> VOL_SHIFT;
                            snd_pos[c] = snd_pos[c] + 1'b1;
                        end
                    end
                end
                acc = (acc * int'(master)) >>> VOL_SHIFT;
                if (acc > MIX_MAX)
                begin
                    acc = MIX_MAX;
                    n_clipped++;
                end
                else if (acc < MIX_MIN)
                begin
                    acc = MIX_MIN;
                    n_clipped++;
                end
                reply.mix = acc[MIX_W-1:0];
            end
            default: ;
        endcase
        return reply;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        mixer_reply_t got;
        mixer_reply_t want;
        if (!rst_n)
        begin
            for (int c = 0; c < CHANNELS; c++)
            begin
                snd_base[c] = '0;
                snd_length[c] = '0;
                snd_pos[c] = '0;
                snd_gain[c] = '0;
                snd_active[c] = 1'b0;
            end
            master = MASTER_AT_RESET;
            awaited_replies.delete();
            n_items = 0;
            n_results = 0;
            n_bad = 0;
            n_clipped = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                got.mix = mixed_sample;
                got.handle = handle_out;
                got.play = playing;
                if (awaited_replies.size() == 0)
                begin
                    n_bad++;
                    if (n_bad <= REPORT_LIMIT)
                        $display("%0t: result transfer with no item waiting: mixed_sample %0d handle_out %0d playing %0b",
                                 $time, $signed(got.mix), got.handle, got.play);
                end
                else
                begin
                    want = awaited_replies.pop_front();
                    if (got.mix !== want.mix || got.handle !== want.handle
                        || got.play !== want.play)
                    begin
                        n_bad++;
                        if (n_bad <= REPORT_LIMIT)
                            $display("%0t: result %0d: mixed_sample exp %0d got %0d, handle_out exp %0d got %0d, playing exp %0b got %0b",
                                     $time, n_results, $signed(want.mix), $signed(got.mix),
                                     want.handle, got.handle, want.play, got.play);
                    end
                end
                n_results++;
            end
            if (in_valid && !in_stall)
            begin
                awaited_replies.push_back(mixer_reply_for(action_t'(action), address, sample_byte,
                                                          sound_length, channel_volume,
                                                          handle_in));
                n_items++;
            end
            if (cfg_valid && cfg_ready)
                master = cfg_data;
        end
        mismatch_total <= n_bad;
        items_taken <= n_items;
        results_taken <= n_results;
        backlog <= awaited_replies.size();
        clipped_frames <= n_clipped;
    end

endmodule

@@ bench/multichannel_pcm_mixer_unit_tb.sv @@
`timescale 1ns / 100ps

module multichannel_pcm_mixer_unit_tb;

    import mpm_pkg::*;

    localparam int CHANNELS    = 8;
    localparam int ITEM_TARGET = 1950;
    localparam int DIRECTED    = 25;
    localparam int PHASES      = 6;
    localparam int LONG_HOLD   = 150;
    localparam int TAIL_CYCLES = 40;
    localparam int MAX_LENGTH  = 65536;
    localparam logic [HANDLE_W-1:0]  NO_HANDLE    = '0;
    localparam logic [ADDRESS_W-1:0] SOUND_REGION = 16'h2000;
    localparam logic [ADDRESS_W-1:0] CHORD_REGION = 16'h3000;

    logic clk = 1'b0;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    action_t action;
    logic [ADDRESS_W-1:0] address;
    logic [BYTE_W-1:0] sample_byte;
    logic [LENGTH_W-1:0] sound_length;
    logic [VOLUME_W-1:0] channel_volume;
    logic [HANDLE_W-1:0] handle_in;
    logic out_valid;
    logic out_stall;
    logic signed [MIX_W-1:0] mixed_sample;
    logic [HANDLE_W-1:0] handle_out;
    logic playing;
    logic cfg_valid;
    logic cfg_ready;
    logic [VOLUME_W-1:0] cfg_data;

    int mismatches;
    int items_taken;
    int results_taken;
    int backlog;
    int clipped_frames;

    bit quiet = 1'b0;
    int hold_requests = 0;
    int holds_served = 0;

    // Channel allocation as the block sees it, kept so that every mix frame reads sample
    // memory that has already been written and so that handles can aim at playing channels.
    bit                   sh_active [CHANNELS];
    logic [ADDRESS_W-1:0] sh_base   [CHANNELS];
    logic [LENGTH_W-1:0]  sh_len    [CHANNELS];
    logic [LENGTH_W-1:0]  sh_pos    [CHANNELS];
    bit                   written   [0:(1 << ADDRESS_W)-1];

    int items_sent = 0;
    int action_count [0:7];
    int steals = 0;
    int master_settings = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    multichannel_pcm_mixer_unit i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .action         (action),
        .address        (address),
        .sample_byte    (sample_byte),
        .sound_length   (sound_length),
        .channel_volume (channel_volume),
        .handle_in      (handle_in),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .mixed_sample   (mixed_sample),
        .handle_out     (handle_out),
        .playing        (playing),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data)
    );

    pcm_mixer_checker #(
        .CHANNELS (CHANNELS)
    ) i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .action         (action),
        .address        (address),
        .sample_byte    (sample_byte),
        .sound_length   (sound_length),
        .channel_volume (channel_volume),
        .handle_in      (handle_in),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .mixed_sample   (mixed_sample),
        .handle_out     (handle_out),
        .playing        (playing),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .mismatch_total (mismatches),
        .items_taken    (items_taken),
        .results_taken  (results_taken),
        .backlog        (backlog),
        .clipped_frames (clipped_frames)
    );

    // Mostly back to back (always while quiet), sometimes a short gap, now and then a long pause.
    function automatic int pick_gap();
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [BYTE_W-1:0] pick_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15)
            return 8'h00;
        if (r < 30)
            return 8'hFF;
        return BYTE_W'($urandom);
    endfunction

    function automatic logic [VOLUME_W-1:0] pick_gain();
        int r;
        r = $urandom_range(0, 99);
        if (r < 20)
            return 7'd127;
        if (r < 30)
            return 7'd0;
        return VOLUME_W'($urandom);
    endfunction

    function automatic logic [LENGTH_W-1:0] pick_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 6)
            return '0;
        if (r < 50)
            return LENGTH_W'($urandom_range(1, 16));
        if (r < 85)
            return LENGTH_W'($urandom_range(17, 400));
        if (r < 93)
            return LENGTH_W'(MAX_LENGTH);
        return LENGTH_W'($urandom_range(0, MAX_LENGTH));
    endfunction

    function automatic logic [ADDRESS_W-1:0] pick_base();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75)
            return SOUND_REGION + ADDRESS_W'($urandom_range(0, 255));
        if (r < 90)
            return ADDRESS_W'($urandom_range(16'hFF00, 16'hFFFF));
        return ADDRESS_W'($urandom);
    endfunction

    // Mostly the handle of a channel that is playing, sometimes any handle, rarely none.
    function automatic logic [HANDLE_W-1:0] pick_handle();
        int r;
        int c0;
        r = $urandom_range(0, 99);
        if (r < 8)
            return NO_HANDLE;
        if (r < 70)
        begin
            c0 = $urandom_range(0, CHANNELS - 1);
            for (int i = 0; i < CHANNELS; i++)
            begin
                if (sh_active[(c0 + i) % CHANNELS])
                    return HANDLE_W'((c0 + i) % CHANNELS + 1);
            end
        end
        return HANDLE_W'($urandom_range(1, CHANNELS));
    endfunction

    function automatic void track_item(action_t act, logic [ADDRESS_W-1:0] addr,
                                       logic [LENGTH_W-1:0] len, logic [HANDLE_W-1:0] hdl);
        int slot;
        slot = -1;
        case (act)
            ACT_WRITE: written[addr] = 1'b1;
            ACT_START:
            begin
                if (len != 0)
                begin
                    for (int c = 0; c < CHANNELS; c++)
                    begin
                        if (slot < 0 && !sh_active[c])
                            slot = c;
                    end
                    if (slot < 0)
                    begin
                        slot = 0;
                        steals++;
                    end
                    sh_active[slot] = 1'b1;
                    sh_base[slot] = addr;
                    sh_len[slot] = len;
                    sh_pos[slot] = '0;
                end
            end
            ACT_STOP:
            begin
                if (hdl >= 1 && hdl <= CHANNELS)
                    sh_active[hdl - 1] = 1'b0;
            end
            ACT_MIX:
            begin
                for (int c = 0; c < CHANNELS; c++)
                begin
                    if (sh_active[c])
                    begin
                        if (sh_pos[c] >= sh_len[c])
                            sh_active[c] = 1'b0;
                        else
                            sh_pos[c] = sh_pos[c] + 1'b1;
                    end
                end
            end
            default: ;
        endcase
    endfunction

    // Called just after clk rises; returns just after the block has taken the transfer.
    task automatic push_item(action_t act, logic [ADDRESS_W-1:0] addr, logic [BYTE_W-1:0] pcm,
                             logic [LENGTH_W-1:0] len, logic [VOLUME_W-1:0] vol,
                             logic [HANDLE_W-1:0] hdl);
        int gap;
        gap = pick_gap();
        track_item(act, addr, len, hdl);
        items_sent++;
        action_count[act]++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        action <= act;
        address <= addr;
        sample_byte <= pcm;
        sound_length <= len;
        channel_volume <= vol;
        handle_in <= hdl;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic send_write(logic [ADDRESS_W-1:0] addr, logic [BYTE_W-1:0] pcm);
        push_item(ACT_WRITE, addr, pcm, LENGTH_W'($urandom_range(0, MAX_LENGTH)),
                  VOLUME_W'($urandom), HANDLE_W'($urandom_range(0, CHANNELS)));
    endtask

    task automatic send_start(logic [ADDRESS_W-1:0] base, logic [LENGTH_W-1:0] len,
                              logic [VOLUME_W-1:0] vol);
        push_item(ACT_START, base, BYTE_W'($urandom), len, vol,
                  HANDLE_W'($urandom_range(0, CHANNELS)));
    endtask

    task automatic send_ctrl(action_t act, logic [HANDLE_W-1:0] hdl, logic [VOLUME_W-1:0] vol);
        push_item(act, ADDRESS_W'($urandom), BYTE_W'($urandom),
                  LENGTH_W'($urandom_range(0, MAX_LENGTH)), vol, hdl);
    endtask

    // Writes any sample that the coming frame will read and that was never written, then sends the mix frame.
    task automatic send_mix();
        logic [ADDRESS_W-1:0] rd;
        for (int c = 0; c < CHANNELS; c++)
        begin
            if (sh_active[c] && sh_pos[c] < sh_len[c])
            begin
                rd = sh_base[c] + sh_pos[c][ADDRESS_W-1:0];
                if (!written[rd])
                    send_write(rd, pick_byte());
            end
        end
        push_item(ACT_MIX, ADDRESS_W'($urandom), BYTE_W'($urandom),
                  LENGTH_W'($urandom_range(0, MAX_LENGTH)), VOLUME_W'($urandom),
                  HANDLE_W'($urandom_range(0, CHANNELS)));
    endtask

    // Eight to ten loud sounds over full-scale samples: fills every channel, steals channel 0
    // once more sounds start than channels are idle, and at a high master volume clips the sum.
    task automatic run_chord();
        logic [ADDRESS_W-1:0] region;
        logic [BYTE_W-1:0] level;
        region = CHORD_REGION + ADDRESS_W'($urandom_range(0, 15) * 16);
        level = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        for (int i = 0; i < 16; i++)
            send_write(region + ADDRESS_W'(i), level);
        repeat ($urandom_range(8, 10))
            send_start(region, LENGTH_W'($urandom_range(4, 12)),
                       VOLUME_W'($urandom_range(100, 127)));
        repeat ($urandom_range(4, 8))
            send_mix();
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (results_taken != items_sent);
    endtask

    task automatic set_master(logic [VOLUME_W-1:0] vol);
        cfg_valid <= 1'b1;
        cfg_data <= vol;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        master_settings++;
    endtask

    initial
    begin : stimulus
        logic [VOLUME_W-1:0] master_plan [PHASES];
        int phase_end;
        int r;
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        action <= ACT_WRITE;
        address <= '0;
        sample_byte <= '0;
        sound_length <= '0;
        channel_volume <= '0;
        handle_in <= '0;
        cfg_valid <= 1'b0;
        cfg_data <= '0;
        for (int i = 0; i < 8; i++)
            action_count[i] = 0;
        master_plan = '{7'd0, 7'd127, 7'd1, 7'd64, VOLUME_W'($urandom_range(2, 126)), 7'd127};
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, master volume still at its reset value.
        send_ctrl(ACT_QUERY, 4'd1, pick_gain());
        send_mix();
        send_start(16'h1234, '0, 7'd127);
        send_write(16'hFFFE, 8'h80);
        send_write(16'hFFFF, 8'hFF);
        send_write(16'h0000, 8'h00);
        // Both sounds run past the top of memory and wrap to address 0.
        send_start(16'hFFFE, 17'd3, 7'd127);
        send_start(16'hFFFF, LENGTH_W'(MAX_LENGTH), 7'd0);
        send_ctrl(ACT_VOLUME, 4'd2, 7'd127);
        repeat (3) send_mix();
        send_ctrl(ACT_QUERY, 4'd1, pick_gain());
        send_mix();
        send_ctrl(ACT_QUERY, 4'd1, pick_gain());
        send_ctrl(ACT_STOP, NO_HANDLE, pick_gain());
        send_ctrl(ACT_VOLUME, NO_HANDLE, 7'd0);
        send_ctrl(ACT_QUERY, NO_HANDLE, pick_gain());
        send_ctrl(ACT_VOLUME, 4'd8, 7'd55);
        send_ctrl(ACT_QUERY, 4'd8, pick_gain());
        send_mix();
        send_ctrl(ACT_STOP, 4'd2, pick_gain());
        send_ctrl(ACT_QUERY, 4'd2, pick_gain());
        send_write(16'hAAAA, 8'h55);
        send_write(16'h5555, 8'hAA);

        for (int p = 0; p < PHASES; p++)
        begin
            wait_drained();
            set_master(master_plan[p]);
            quiet = (p == 3);
            run_chord();
            // The sink holds off for a long stretch while items keep coming.
            if (p == 1)
                hold_requests++;
            phase_end = DIRECTED + (p + 1) * ((ITEM_TARGET - DIRECTED) / PHASES);
            while (items_sent < phase_end)
            begin
                r = $urandom_range(0, 99);
                if (r < 38)
                    send_mix();
                else if (r < 53)
                    send_start(pick_base(), pick_length(), pick_gain());
                else if (r < 66)
                    send_write($urandom_range(0, 1) ?
                               SOUND_REGION + ADDRESS_W'($urandom_range(0, 16'h2FF)) :
                               ADDRESS_W'($urandom), pick_byte());
                else if (r < 74)
                    send_ctrl(ACT_STOP, pick_handle(), pick_gain());
                else if (r < 83)
                    send_ctrl(ACT_VOLUME, pick_handle(), pick_gain());
                else
                    send_ctrl(ACT_QUERY, pick_handle(), pick_gain());
            end
        end
        quiet = 1'b0;
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Sent %0d items: %0d writes, %0d starts, %0d stops, %0d volume sets, %0d queries, %0d mix frames",
                 items_sent, action_count[ACT_WRITE], action_count[ACT_START],
                 action_count[ACT_STOP], action_count[ACT_VOLUME], action_count[ACT_QUERY],
                 action_count[ACT_MIX]);
        $display("Checked %0d results under %0d master volume settings, with %0d channel steals and %0d clipped frames",
                 results_taken, master_settings, steals, clipped_frames);
        if (mismatches == 0 && backlog == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin : result_sink
        int len;
        out_stall <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (holds_served != hold_requests)
            begin
                holds_served++;
                len = LONG_HOLD;
            end
            else
                len = pick_gap();
            if (len > 0)
            begin
                out_stall <= 1'b1;
                repeat (len) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
        end
    end

    initial
    begin : watchdog
        #20_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
